/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL files that carry checks.
// Each check is clocked on clk_i and switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_PROP(label, !(cond), msg)

`endif

/* hw/rtl/rsf_pkg.sv */
`default_nettype none

package rsf_pkg;

  // Width and reset value of the radius register.
  localparam int unsigned RadiusBits  = 20;
  localparam int unsigned TagBits     = 16;
  localparam logic [RadiusBits-1:0] RadiusReset = 20'd100;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StDone = 3'b100
  } rsf_state_e;

  // Status of the distance pipeline towards the sequencer.
  typedef struct packed {
    logic busy;       // some stage still holds an entry
    logic hit_valid;  // the output stage holds a finished comparison
    logic hit;        // that entry lies within the radius
  } rsf_dist_status_t;

endpackage

`default_nettype wire

/* hw/rtl/radius_suppression_filter.sv */
// Greedy radius suppression over batches of points.
// Input channel: point_x_i, point_y_i, tag_i and last_i with in_valid_i;
// an item is taken at a rising edge where in_valid_i is high and
// in_stall_o is low. Output channel: tag_out_o, keep_o, overflow_o and
// last_out_o with out_valid_o; the result is taken where out_valid_o is
// high and out_stall_i is low. One result follows every point.
// The radius register is written through cfg_valid_i / cfg_data_i and
// cfg_ready_o, which is always high; write it only while the block is idle.
// Each point is compared with every kept point of its batch, one stored
// entry per cycle through a memory read and a three-stage distance
// pipeline; the input stays stalled during that scan. The next point is
// taken the cycle after the result is registered. If the receiver
// stalls, the result waits in the output register and the following
// point is scanned, but its result and store update wait until the
// output register is free. Reset empties the store, sets the radius to
// 100 and leaves no result pending. A point with last set empties the
// store once it has been handled.
`default_nettype none

module radius_suppression_filter #(
  parameter int unsigned MAX_KEPT   = 64,
  parameter int unsigned COORD_BITS = 20
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration write
  input  wire logic                               cfg_valid_i,
  output wire logic                               cfg_ready_o,
  input  wire logic [rsf_pkg::RadiusBits-1:0]     cfg_data_i,
  // Input points
  input  wire logic                               in_valid_i,
  output wire logic                               in_stall_o,
  input  wire logic signed [COORD_BITS-1:0]       point_x_i,
  input  wire logic signed [COORD_BITS-1:0]       point_y_i,
  input  wire logic [rsf_pkg::TagBits-1:0]        tag_i,
  input  wire logic                               last_i,
  // Results
  output wire logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  output wire logic [rsf_pkg::TagBits-1:0]        tag_out_o,
  output wire logic                               keep_o,
  output wire logic                               overflow_o,
  output wire logic                               last_out_o
);

  `include "assert_macros.svh"

  localparam int unsigned CntBits  = $clog2(MAX_KEPT + 1);
  localparam int unsigned AddrBits = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned R2Bits   = 2 * rsf_pkg::RadiusBits;
  localparam int unsigned EntBits  = 2 * COORD_BITS;

  rsf_pkg::rsf_state_e               state_q, state_d;
  logic [rsf_pkg::RadiusBits-1:0]    radius_q;
  logic [R2Bits-1:0]                 r2_q;
  logic [CntBits-1:0]                kept_count_q, kept_count_d;
  logic [CntBits-1:0]                rd_idx_q, rd_idx_d;
  logic                              hit_q, hit_d;
  logic                              mem_valid_q;
  logic signed [COORD_BITS-1:0]      px_q, py_q;
  logic [rsf_pkg::TagBits-1:0]       tag_q;
  logic                              last_q;
  logic                              out_valid_q, out_valid_d;
  logic [rsf_pkg::TagBits-1:0]       tag_out_q;
  logic                              keep_q, overflow_q, last_out_q;
  logic [EntBits-1:0]                mem [MAX_KEPT];
  logic [EntBits-1:0]                rd_data_q;
  logic                              rd_en, wr_en, in_take, out_free, store_full;
  rsf_pkg::rsf_dist_status_t         dist_status;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != rsf_pkg::StIdle);
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign store_full  = (kept_count_q >= CntBits'(MAX_KEPT));

  // Reads walk the valid entries of the store; the write lands at the end.
  assign rd_en = (state_q == rsf_pkg::StScan) && (rd_idx_q < kept_count_q);
  assign wr_en = (state_q == rsf_pkg::StDone) && out_free && !hit_q && !store_full;

  // Sequencer and result bookkeeping.
  always_comb begin
    state_d      = state_q;
    kept_count_d = kept_count_q;
    rd_idx_d     = rd_idx_q;
    hit_d        = hit_q | (dist_status.hit_valid & dist_status.hit);
    out_valid_d  = out_valid_q && out_stall_i;
    case (state_q)
      rsf_pkg::StIdle: begin
        if (in_take) begin
          rd_idx_d = '0;
          hit_d    = 1'b0;
          state_d  = rsf_pkg::StScan;
        end
      end
      rsf_pkg::StScan: begin
        if (rd_en) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end else if (!mem_valid_q && !dist_status.busy) begin
          state_d = rsf_pkg::StDone;
        end
      end
      rsf_pkg::StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (last_q) begin
            kept_count_d = '0;
          end else if (wr_en) begin
            kept_count_d = kept_count_q + 1'b1;
          end
          state_d = rsf_pkg::StIdle;
        end
      end
      default: begin
        state_d = rsf_pkg::StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rsf_pkg::StIdle;
      radius_q     <= rsf_pkg::RadiusReset;
      kept_count_q <= '0;
      rd_idx_q     <= '0;
      hit_q        <= 1'b0;
      mem_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      kept_count_q <= kept_count_d;
      rd_idx_q     <= rd_idx_d;
      hit_q        <= hit_d;
      mem_valid_q  <= rd_en;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        radius_q <= cfg_data_i;
      end
    end
  end

  // Point capture, radius squared and the result register.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      px_q   <= point_x_i;
      py_q   <= point_y_i;
      tag_q  <= tag_i;
      last_q <= last_i;
      r2_q   <= R2Bits'(radius_q) * R2Bits'(radius_q);
    end
    if ((state_q == rsf_pkg::StDone) && out_free) begin
      tag_out_q  <= tag_q;
      keep_q     <= !hit_q;
      overflow_q <= !hit_q && store_full;
      last_out_q <= last_q;
    end
  end

  // Store of kept points, x in the upper half and y in the lower half.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[kept_count_q[AddrBits-1:0]] <= {px_q, py_q};
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_idx_q[AddrBits-1:0]];
    end
  end

  // Distance pipeline fed by the store read data.
  rsf_dist_pipe #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (mem_valid_q),
    .entry_x_i     (rd_data_q[EntBits-1:COORD_BITS]),
    .entry_y_i     (rd_data_q[COORD_BITS-1:0]),
    .point_x_i     (px_q),
    .point_y_i     (py_q),
    .r2_i          (r2_q),
    .status_o      (dist_status)
  );

  assign out_valid_o = out_valid_q;
  assign tag_out_o   = tag_out_q;
  assign keep_o      = keep_q;
  assign overflow_o  = overflow_q;
  assign last_out_o  = last_out_q;

  // Checks on the sequencer and the store.
  `ASSERT_NEVER(a_count_bound, kept_count_q > CntBits'(MAX_KEPT), "kept count beyond store size")
  `ASSERT_NEVER(a_rw_overlap, rd_en && wr_en, "store written while a scan is reading")
  `ASSERT_PROP(a_rd_in_range, rd_en |-> (rd_idx_q < kept_count_q), "read beyond kept entries")
  `ASSERT_PROP(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == rsf_pkg::StDone),
               "result raised outside the finishing state")

endmodule

`default_nettype wire

/* hw/rtl/rsf_dist_pipe.sv */
`default_nettype none

module rsf_dist_pipe #(
  parameter int unsigned COORD_BITS = 20
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 entry_valid_i,
  input  wire logic signed [COORD_BITS-1:0]         entry_x_i,
  input  wire logic signed [COORD_BITS-1:0]         entry_y_i,
  input  wire logic signed [COORD_BITS-1:0]         point_x_i,
  input  wire logic signed [COORD_BITS-1:0]         point_y_i,
  input  wire logic [2*rsf_pkg::RadiusBits-1:0]     r2_i,
  output rsf_pkg::rsf_dist_status_t                 status_o
);

  // The magnitude of a coordinate difference always fits in COORD_BITS bits.
  localparam int unsigned SqBits  = 2 * COORD_BITS;
  localparam int unsigned SumBits = SqBits + 1;
  localparam int unsigned R2Bits  = 2 * rsf_pkg::RadiusBits;
  localparam int unsigned CmpBits = (SumBits > R2Bits) ? SumBits : R2Bits;

  logic                  s1_valid_q, s2_valid_q, s3_valid_q;
  logic [COORD_BITS-1:0] dx_q, dy_q, dx_d, dy_d;
  logic [SqBits-1:0]     dx2_q, dy2_q;
  logic                  hit_q, hit_d;
  logic [COORD_BITS:0]   diff_x, diff_y;
  logic [COORD_BITS:0]   mag_x, mag_y;
  logic [SumBits-1:0]    sum;

  // Stage one: absolute differences, formed one bit wider and folded back.
  always_comb begin
    diff_x = {point_x_i[COORD_BITS-1], point_x_i} - {entry_x_i[COORD_BITS-1], entry_x_i};
    diff_y = {point_y_i[COORD_BITS-1], point_y_i} - {entry_y_i[COORD_BITS-1], entry_y_i};
    mag_x  = diff_x[COORD_BITS] ? (~diff_x + 1'b1) : diff_x;
    mag_y  = diff_y[COORD_BITS] ? (~diff_y + 1'b1) : diff_y;
    dx_d   = mag_x[COORD_BITS-1:0];
    dy_d   = mag_y[COORD_BITS-1:0];
  end

  // Stage three input: the exact sum of squares against radius squared.
  always_comb begin
    sum   = {1'b0, dx2_q} + {1'b0, dy2_q};
    hit_d = (CmpBits'(sum) <= CmpBits'(r2_i));
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= entry_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Datapath registers: differences, squares and the comparison result.
  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    dx2_q <= SqBits'(dx_q) * SqBits'(dx_q);
    dy2_q <= SqBits'(dy_q) * SqBits'(dy_q);
    hit_q <= hit_d;
  end

  assign status_o.busy      = s1_valid_q | s2_valid_q | s3_valid_q;
  assign status_o.hit_valid = s3_valid_q;
  assign status_o.hit       = hit_q;

endmodule

`default_nettype wire
